// ===== sv/hmdp_pkg.sv =====
package hmdp_pkg;

    localparam int RACK_TILES_DEF = 7;
    localparam int WIDE_W = 64;
    localparam int PROB_W = 33;
    localparam int DIV_STEPS = 64;
    localparam int FRAC_STEPS = 32;
    localparam int STEP_CNT_W = 7;

    localparam logic [PROB_W-1:0] PROB_ONE = 33'h1_0000_0000;

    localparam logic [1:0] CODE_CALC = 2'd0;
    localparam logic [1:0] CODE_CERTAIN = 2'd1;
    localparam logic [1:0] CODE_SHORT = 2'd2;
    localparam logic [1:0] CODE_NONE = 2'd3;

    typedef struct packed {
        logic       start;
        logic       frac;
        logic [7:0] mult;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

// ===== sv/hmdp_if.sv =====
interface hmdp_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] letter_held;
    logic [2:0] rack_held_total;
    logic [2:0] tiles_played;
    logic [7:0] letter_in_bag;
    logic [7:0] bag_total;
    logic [2:0] minimum_wanted;

    modport source (
        output valid, letter_held, rack_held_total, tiles_played,
               letter_in_bag, bag_total, minimum_wanted,
        input  ready
    );
    modport sink (
        input  valid, letter_held, rack_held_total, tiles_played,
               letter_in_bag, bag_total, minimum_wanted,
        output ready
    );
endinterface

interface hmdp_out_if;
    logic        valid;
    logic        ready;
    logic [32:0] probability_q32;
    logic [1:0]  case_code;

    modport source (
        output valid, probability_q32, case_code,
        input  ready
    );
    modport sink (
        input  valid, probability_q32, case_code,
        output ready
    );
endinterface

// ===== sv/hmdp_div.sv =====
module hmdp_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  hmdp_pkg::div_req_t               req,
    input  logic [hmdp_pkg::WIDE_W-1:0]      a,
    input  logic [hmdp_pkg::WIDE_W-1:0]      den,
    output hmdp_pkg::div_sts_t               sts,
    output logic [hmdp_pkg::WIDE_W-1:0]      quot
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [hmdp_pkg::STEP_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [hmdp_pkg::WIDE_W-1:0]         rem_reg, rem_next;
    logic [hmdp_pkg::WIDE_W-1:0]         sh_reg, sh_next;
    logic [hmdp_pkg::WIDE_W-1:0]         q_reg, q_next;
    logic [hmdp_pkg::WIDE_W-1:0]         den_reg, den_next;
    logic [hmdp_pkg::WIDE_W:0]           rem2;
    logic [hmdp_pkg::WIDE_W:0]           diff;
    logic                                ge;
    logic [hmdp_pkg::WIDE_W-1:0]         prod;

    // In binomial mode the dividend is the product; in fraction mode the
    // remainder starts at the numerator and zeros are shifted in.
    assign prod = a * hmdp_pkg::WIDE_W'(req.mult);
    assign rem2 = {rem_reg, sh_reg[hmdp_pkg::WIDE_W-1]};
    assign diff = rem2 - {1'b0, den_reg};
    assign ge   = (rem2 >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            den_next  = den;
            q_next    = '0;
            if (req.frac)
            begin
                cnt_next = hmdp_pkg::STEP_CNT_W'(hmdp_pkg::FRAC_STEPS);
                rem_next = a;
                sh_next  = '0;
            end
            else
            begin
                cnt_next = hmdp_pkg::STEP_CNT_W'(hmdp_pkg::DIV_STEPS);
                rem_next = '0;
                sh_next  = prod;
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[hmdp_pkg::WIDE_W-1:0] : rem2[hmdp_pkg::WIDE_W-1:0];
            q_next   = {q_reg[hmdp_pkg::WIDE_W-2:0], ge};
            sh_next  = {sh_reg[hmdp_pkg::WIDE_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == hmdp_pkg::STEP_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quot     = q_reg;

endmodule

// ===== sv/hypergeometric_minimum_draw_prob.sv =====
// Probability that a partial rack, filled at random from the bag, ends with
// at least a minimum count of one letter (hypergeometric tail).
// Channel req carries one query word; channel rsp returns one result word
// with a Q1.32 probability (2^32 means certain) and a case code.
// The block takes one query at a time: req.ready is high only while idle.
// Trivial cases (already met, too few, inconsistent, bag emptied, no draws)
// are answered in the cycle after acceptance. Otherwise the sequencer walks
// C(n,d) and, for each term of the tail, C(k,i) times C(n-k,d-i), with one
// multiply-then-divide step per binomial factor on a shared bit-serial
// divider of 64 steps, then a 32-step fraction division. The result word
// is held on rsp until rsp.ready; the next query is accepted only after
// that. Reset returns the block to idle with no word pending.
module hypergeometric_minimum_draw_prob #(
    parameter int RACK_TILES = hmdp_pkg::RACK_TILES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    hmdp_in_if.sink            req,
    hmdp_out_if.source         rsp
);

    localparam int D_BITS = $clog2(RACK_TILES + 2);
    localparam int CNT_W = (D_BITS > 3) ? D_BITS : 3;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_STEP  = 7'b0000010,
        S_WAIT  = 7'b0000100,
        S_TERM  = 7'b0001000,
        S_FRAC  = 7'b0010000,
        S_FWAIT = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    typedef enum logic [2:0] {
        PH_TOTAL = 3'b001,
        PH_A     = 3'b010,
        PH_B     = 3'b100
    } phase_t;

    state_t                          state_reg, state_next;
    phase_t                          phase_reg, phase_next;
    logic [CNT_W-1:0]                j_reg, j_next;
    logic [CNT_W-1:0]                r_reg, r_next;
    logic [CNT_W-1:0]                i_reg, i_next;
    logic [CNT_W-1:0]                d_reg, d_next;
    logic [7:0]                      m_reg, m_next;
    logic [7:0]                      k_reg, k_next;
    logic [7:0]                      n_reg, n_next;
    logic [hmdp_pkg::WIDE_W-1:0]     acc_reg, acc_next;
    logic [hmdp_pkg::WIDE_W-1:0]     total_reg, total_next;
    logic [hmdp_pkg::WIDE_W-1:0]     hits_reg, hits_next;
    logic [hmdp_pkg::PROB_W-1:0]     prob_reg, prob_next;
    logic [1:0]                      code_reg, code_next;

    logic [7:0]                      k_sat;
    logic [2:0]                      need;
    logic [4:0]                      sum5;
    logic [4:0]                      d_full;
    logic [CNT_W-1:0]                dmi;
    logic [7:0]                      nmk;

    hmdp_pkg::div_req_t              div_req;
    hmdp_pkg::div_sts_t              div_sts;
    logic [hmdp_pkg::WIDE_W-1:0]     div_a;
    logic [hmdp_pkg::WIDE_W-1:0]     div_den;
    logic [hmdp_pkg::WIDE_W-1:0]     div_q;

    hmdp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .a     (div_a),
        .den   (div_den),
        .sts   (div_sts),
        .quot  (div_q)
    );

    assign k_sat  = (req.letter_in_bag > req.bag_total) ? req.bag_total : req.letter_in_bag;
    assign need   = req.minimum_wanted - req.letter_held;
    assign sum5   = 5'(req.rack_held_total) + 5'(req.tiles_played);
    assign d_full = 5'(RACK_TILES) - sum5;
    assign dmi    = d_reg - i_reg;
    assign nmk    = n_reg - k_reg;

    assign div_a   = (state_reg == S_FRAC) ? hits_reg : acc_reg;
    assign div_den = (state_reg == S_FRAC) ? total_reg
                                           : hmdp_pkg::WIDE_W'(j_reg) + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        j_next     = j_reg;
        r_next     = r_reg;
        i_next     = i_reg;
        d_next     = d_reg;
        m_next     = m_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        acc_next   = acc_reg;
        total_next = total_reg;
        hits_next  = hits_reg;
        prob_next  = prob_reg;
        code_next  = code_reg;
        div_req.start = 1'b0;
        div_req.frac  = 1'b0;
        div_req.mult  = m_reg - 8'(j_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    k_next     = k_sat;
                    n_next     = req.bag_total;
                    d_next     = d_full[CNT_W-1:0];
                    i_next     = CNT_W'(need);
                    prob_next  = '0;
                    state_next = S_OUT;
                    if (req.minimum_wanted <= req.letter_held)
                    begin
                        prob_next = hmdp_pkg::PROB_ONE;
                        code_next = hmdp_pkg::CODE_CERTAIN;
                    end
                    else if (k_sat < 8'(need))
                    begin
                        code_next = hmdp_pkg::CODE_SHORT;
                    end
                    else if (sum5 > 5'(RACK_TILES))
                    begin
                        code_next = hmdp_pkg::CODE_NONE;
                    end
                    else if (req.bag_total <= 8'(d_full))
                    begin
                        prob_next = hmdp_pkg::PROB_ONE;
                        code_next = hmdp_pkg::CODE_CERTAIN;
                    end
                    else if (d_full == 5'd0)
                    begin
                        code_next = hmdp_pkg::CODE_NONE;
                    end
                    else
                    begin
                        acc_next   = hmdp_pkg::WIDE_W'(1);
                        hits_next  = '0;
                        j_next     = '0;
                        r_next     = d_full[CNT_W-1:0];
                        m_next     = req.bag_total;
                        phase_next = PH_TOTAL;
                        state_next = S_STEP;
                    end
                end
            end
            S_STEP:
            begin
                if (j_reg != r_reg)
                begin
                    div_req.start = 1'b1;
                    state_next    = S_WAIT;
                end
                else
                begin
                    case (phase_reg)
                        PH_TOTAL:
                        begin
                            total_next = acc_reg;
                            state_next = S_TERM;
                        end
                        PH_A:
                        begin
                            j_next     = '0;
                            r_next     = dmi;
                            m_next     = nmk;
                            phase_next = PH_B;
                        end
                        PH_B:
                        begin
                            hits_next  = hits_reg + acc_reg;
                            i_next     = i_reg + 1'b1;
                            state_next = S_TERM;
                        end
                        default:
                        begin
                            state_next = S_TERM;
                        end
                    endcase
                end
            end
            S_WAIT:
            begin
                if (div_sts.done)
                begin
                    acc_next   = div_q;
                    j_next     = j_reg + 1'b1;
                    state_next = S_STEP;
                end
            end
            S_TERM:
            begin
                if (i_reg > d_reg)
                begin
                    state_next = S_FRAC;
                end
                else if ((8'(i_reg) > k_reg) || (8'(dmi) > nmk))
                begin
                    // A zero binomial factor: the term adds nothing.
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    acc_next   = hmdp_pkg::WIDE_W'(1);
                    j_next     = '0;
                    r_next     = i_reg;
                    m_next     = k_reg;
                    phase_next = PH_A;
                    state_next = S_STEP;
                end
            end
            S_FRAC:
            begin
                if (total_reg == '0)
                begin
                    prob_next  = '0;
                    code_next  = hmdp_pkg::CODE_NONE;
                    state_next = S_OUT;
                end
                else if (hits_reg >= total_reg)
                begin
                    prob_next  = hmdp_pkg::PROB_ONE;
                    code_next  = hmdp_pkg::CODE_CALC;
                    state_next = S_OUT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.frac  = 1'b1;
                    state_next    = S_FWAIT;
                end
            end
            S_FWAIT:
            begin
                if (div_sts.done)
                begin
                    prob_next  = {1'b0, div_q[31:0]};
                    code_next  = hmdp_pkg::CODE_CALC;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_TOTAL;
            j_reg     <= '0;
            r_reg     <= '0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            j_reg     <= j_next;
            r_reg     <= r_next;
            i_reg     <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg     <= d_next;
        m_reg     <= m_next;
        k_reg     <= k_next;
        n_reg     <= n_next;
        acc_reg   <= acc_next;
        total_reg <= total_next;
        hits_reg  <= hits_next;
        prob_reg  <= prob_next;
        code_reg  <= code_next;
    end

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = (state_reg == S_OUT);
    assign rsp.probability_q32 = prob_reg;
    assign rsp.case_code       = code_reg;

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid))
        else $error("query taken while a result word is pending");

    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> (state_reg == S_WAIT || state_reg == S_FWAIT))
        else $error("divider finished with no step waiting");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_sts.busy)
        else $error("divider started while busy");

    a_certain: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.case_code == hmdp_pkg::CODE_CERTAIN)
            |-> (rsp.probability_q32 == hmdp_pkg::PROB_ONE))
        else $error("certain case without probability one");
`endif

endmodule
